/* rtl/core/arc4_keystream_cipher_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ARC4 keystream cipher checker.
// Both macros sample on the rising edge of clock and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARC4_KEYSTREAM_CIPHER_MACROS_SVH
`define ARC4_KEYSTREAM_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARC4_ASSERT_SAME(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARC4_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/core/arc4_pkg.sv */
// ----------------------------------------------------------------------------
// ARC4 package
// Shared sizes, operation codes and sequencer states of the cipher engine.
// ----------------------------------------------------------------------------
package arc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 9;
   localparam int PERM_DEPTH = 256;
   localparam int PERM_AW    = 8;
   localparam int KEY_DEPTH  = 256;
   localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   localparam logic [LEN_W-1:0]   KEY_LENGTH_RESET = 9'd16;
   localparam logic [PERM_AW-1:0] PERM_LAST        = PERM_AW'(PERM_DEPTH - 1);

   localparam logic [1:0] OP_KEY_WRITE = 2'd0;
   localparam logic [1:0] OP_SCHEDULE  = 2'd1;
   localparam logic [1:0] OP_DATA      = 2'd2;

   typedef enum logic [3:0] {
      ST_FILL,
      ST_IDLE,
      ST_KS_READ,
      ST_KS_SUM,
      ST_KS_SWAP_K,
      ST_KS_SWAP_J,
      ST_DT_READ_J,
      ST_DT_SWAP_I,
      ST_DT_SWAP_J
   } state_type;

endpackage

/* rtl/core/arc4_ram.sv */
// ----------------------------------------------------------------------------
// ARC4 generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/arc4_keystream_cipher.sv */
// ----------------------------------------------------------------------------
// ARC4 keystream cipher
// RC4 engine with a permutation RAM, a key RAM and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// A command word is taken when start is high and busy is low. The operation
// selects a key byte write, a key schedule or a data byte.
// A key byte write completes at the accepting edge and never raises busy.
// A key schedule keeps busy high while it loads the identity into the
// permutation RAM and runs 256 rounds of read, sum, swap-k and swap-j states.
// A data byte keeps busy high through the read-j, swap-i and swap-j states;
// the result word appears on rsp_out_byte with rsp_strobe high as busy falls,
// which is also the first cycle in which the next command can be taken.
// A data byte is taken only once the last one is through, held back by the
// three dependent reads through the single read port of the permutation RAM.
// After reset the block runs a pass that loads the identity and holds busy
// high meanwhile; csr writes are taken at any time.
// The receiver cannot stall: each result word is shown for one cycle only.
// ----------------------------------------------------------------------------
module arc4_keystream_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_key_index,
   input  logic [7:0]                      req_value,
   output logic                            rsp_strobe,
   output logic [7:0]                      rsp_out_byte,
   input  logic                            csr_write_enable,
   input  logic [arc4_pkg::LEN_W-1:0]      csr_write_data
);

   arc4_pkg::state_type state_ff, state_in;

   logic                              sched_ff, sched_in;
   logic [arc4_pkg::PERM_AW-1:0]      cnt_ff, cnt_in;
   logic [arc4_pkg::KEY_AW-1:0]       key_pos_ff, key_pos_in;
   logic [arc4_pkg::LEN_W-1:0]        eff_len_ff, eff_len_in;
   logic [arc4_pkg::LEN_W-1:0]        key_length_ff, key_length_in;
   logic [7:0]                        i_ff, i_in;
   logic [7:0]                        j_ff, j_in;
   logic [7:0]                        si_ff, si_in;
   logic [7:0]                        sj_ff, sj_in;
   logic [7:0]                        t_ff, t_in;
   logic [7:0]                        value_ff, value_in;
   logic [7:0]                        out_byte_ff, out_byte_in;
   logic                              strobe_ff, strobe_in;

   logic                              accept;
   logic [7:0]                        alu_a, alu_b, alu_c, alu_sum;
   logic [7:0]                        ks_byte;
   logic                              key_wrap;

   logic                              perm_we;
   logic [arc4_pkg::PERM_AW-1:0]      perm_waddr, perm_raddr;
   logic [7:0]                        perm_wdata, perm_rdata;
   logic                              key_we;
   logic [arc4_pkg::KEY_AW-1:0]       key_waddr, key_raddr;
   logic [7:0]                        key_wdata, key_rdata;

   assign accept = start && (state_ff == arc4_pkg::ST_IDLE);
   assign busy   = (state_ff != arc4_pkg::ST_IDLE);

   arc4_ram #(
      .WIDTH (arc4_pkg::BYTE_W),
      .DEPTH (arc4_pkg::PERM_DEPTH)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_waddr),
      .wr_data (perm_wdata),
      .rd_addr (perm_raddr),
      .rd_data (perm_rdata)
   );

   arc4_ram #(
      .WIDTH (arc4_pkg::BYTE_W),
      .DEPTH (arc4_pkg::KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   // The adder shared by the i, j and t updates; its operands follow the sequencer state.
   always_comb begin
      alu_a = i_ff;
      alu_b = 8'd0;
      alu_c = 8'd0;
      unique case (state_ff)
         arc4_pkg::ST_IDLE: begin
            alu_b = 8'd1;
         end
         arc4_pkg::ST_DT_READ_J: begin
            alu_a = j_ff;
            alu_b = perm_rdata;
         end
         arc4_pkg::ST_DT_SWAP_I: begin
            alu_a = si_ff;
            alu_b = perm_rdata;
         end
         arc4_pkg::ST_KS_SUM: begin
            alu_a = j_ff;
            alu_b = perm_rdata;
            alu_c = key_rdata;
         end
         default: begin
            alu_a = i_ff;
         end
      endcase
   end

   assign alu_sum  = alu_a + alu_b + alu_c;
   assign key_wrap = ((arc4_pkg::LEN_W'(key_pos_ff) + arc4_pkg::LEN_W'(1)) == eff_len_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arc4_pkg::ST_FILL: begin
            if (cnt_ff == arc4_pkg::PERM_LAST) begin
               state_in = sched_ff ? arc4_pkg::ST_KS_READ : arc4_pkg::ST_IDLE;
            end
         end
         arc4_pkg::ST_IDLE: begin
            if (accept && (req_operation == arc4_pkg::OP_SCHEDULE)) begin
               state_in = arc4_pkg::ST_FILL;
            end else if (accept && (req_operation == arc4_pkg::OP_DATA)) begin
               state_in = arc4_pkg::ST_DT_READ_J;
            end
         end
         arc4_pkg::ST_KS_READ:   state_in = arc4_pkg::ST_KS_SUM;
         arc4_pkg::ST_KS_SUM:    state_in = arc4_pkg::ST_KS_SWAP_K;
         arc4_pkg::ST_KS_SWAP_K: state_in = arc4_pkg::ST_KS_SWAP_J;
         arc4_pkg::ST_KS_SWAP_J: begin
            state_in = (cnt_ff == arc4_pkg::PERM_LAST) ? arc4_pkg::ST_IDLE
                                                       : arc4_pkg::ST_KS_READ;
         end
         arc4_pkg::ST_DT_READ_J: state_in = arc4_pkg::ST_DT_SWAP_I;
         arc4_pkg::ST_DT_SWAP_I: state_in = arc4_pkg::ST_DT_SWAP_J;
         arc4_pkg::ST_DT_SWAP_J: state_in = arc4_pkg::ST_IDLE;
         default:                state_in = arc4_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      sched_in      = sched_ff;
      cnt_in        = cnt_ff;
      key_pos_in    = key_pos_ff;
      eff_len_in    = eff_len_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      si_in         = si_ff;
      sj_in         = sj_ff;
      t_in          = t_ff;
      value_in      = value_ff;
      out_byte_in   = out_byte_ff;
      strobe_in     = 1'b0;
      ks_byte       = perm_rdata;
      key_length_in = csr_write_enable ? csr_write_data : key_length_ff;

      perm_we    = 1'b0;
      perm_waddr = cnt_ff;
      perm_wdata = cnt_ff;
      perm_raddr = cnt_ff;
      key_we     = 1'b0;
      key_waddr  = req_key_index[arc4_pkg::KEY_AW-1:0];
      key_wdata  = req_value;
      key_raddr  = key_pos_ff;

      unique case (state_ff)
         arc4_pkg::ST_FILL: begin
            perm_we = 1'b1;
            cnt_in  = cnt_ff + 8'd1;
            if (cnt_ff == arc4_pkg::PERM_LAST) begin
               sched_in   = 1'b0;
               key_pos_in = '0;
               j_in       = 8'd0;
            end
         end
         arc4_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  arc4_pkg::OP_KEY_WRITE: begin
                     key_we = ({1'b0, req_key_index} < arc4_pkg::LEN_W'(arc4_pkg::KEY_DEPTH));
                  end
                  arc4_pkg::OP_SCHEDULE: begin
                     sched_in = 1'b1;
                     cnt_in   = '0;
                     if (key_length_ff == '0) begin
                        eff_len_in = arc4_pkg::LEN_W'(1);
                     end else if (key_length_ff > arc4_pkg::LEN_W'(arc4_pkg::KEY_DEPTH)) begin
                        eff_len_in = arc4_pkg::LEN_W'(arc4_pkg::KEY_DEPTH);
                     end else begin
                        eff_len_in = key_length_ff;
                     end
                  end
                  arc4_pkg::OP_DATA: begin
                     value_in   = req_value;
                     i_in       = alu_sum;
                     perm_raddr = alu_sum;
                  end
                  default: begin
                     value_in = value_ff;
                  end
               endcase
            end
         end
         arc4_pkg::ST_KS_READ: begin
            perm_raddr = cnt_ff;
            key_raddr  = key_pos_ff;
         end
         arc4_pkg::ST_KS_SUM: begin
            si_in      = perm_rdata;
            j_in       = alu_sum;
            perm_raddr = alu_sum;
         end
         arc4_pkg::ST_KS_SWAP_K: begin
            perm_we    = 1'b1;
            perm_waddr = cnt_ff;
            perm_wdata = perm_rdata;
         end
         arc4_pkg::ST_KS_SWAP_J: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            cnt_in     = cnt_ff + 8'd1;
            key_pos_in = key_wrap ? '0 : key_pos_ff + arc4_pkg::KEY_AW'(1);
            if (cnt_ff == arc4_pkg::PERM_LAST) begin
               i_in = 8'd0;
               j_in = 8'd0;
            end
         end
         arc4_pkg::ST_DT_READ_J: begin
            si_in      = perm_rdata;
            j_in       = alu_sum;
            perm_raddr = alu_sum;
         end
         arc4_pkg::ST_DT_SWAP_I: begin
            sj_in      = perm_rdata;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rdata;
            t_in       = alu_sum;
            perm_raddr = alu_sum;
         end
         arc4_pkg::ST_DT_SWAP_J: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            // The keystream entry may be one of the two just swapped.
            if (t_ff == j_ff) begin
               ks_byte = si_ff;
            end else if (t_ff == i_ff) begin
               ks_byte = sj_ff;
            end else begin
               ks_byte = perm_rdata;
            end
            out_byte_in = value_ff ^ ks_byte;
            strobe_in   = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arc4_pkg::ST_FILL;
         sched_ff      <= 1'b0;
         cnt_ff        <= '0;
         key_pos_ff    <= '0;
         key_length_ff <= arc4_pkg::KEY_LENGTH_RESET;
         i_ff          <= 8'd0;
         j_ff          <= 8'd0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sched_ff      <= sched_in;
         cnt_ff        <= cnt_in;
         key_pos_ff    <= key_pos_in;
         key_length_ff <= key_length_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      eff_len_ff  <= eff_len_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      value_ff    <= value_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_byte = out_byte_ff;

endmodule

/* rtl/core/arc4_checker.sv */
// ----------------------------------------------------------------------------
// ARC4 port checker
// Timing properties of the command and result ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "arc4_keystream_cipher_macros.svh"

module arc4_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_operation,
   input logic       rsp_strobe
);

   logic accept;
   logic key_accept;
   logic data_accept;

   assign accept      = start && !busy;
   assign key_accept  = accept && (req_operation == arc4_pkg::OP_KEY_WRITE);
   assign data_accept = accept && (req_operation == arc4_pkg::OP_DATA);

   `ARC4_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result held two cycles")
   `ARC4_ASSERT_SAME(a_strobe_when_free, rsp_strobe, !busy, "result shown while busy")
   `ARC4_ASSERT_NEXT(a_key_write_free, key_accept, !busy, "key write raised busy")
   `ARC4_ASSERT_SAME(a_strobe_latency, rsp_strobe, $past(data_accept, 4), "stray result")

endmodule

bind arc4_keystream_cipher arc4_checker u_arc4_checker (.*);

/* tb/sv/arc4_keystream_cipher_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARC4 keystream cipher testbench
// Drives key writes, key schedules and data bytes through the command port,
// changes the key length between phases, and checks every result word
// against a keystream predictor kept in step with the accepted commands.
// ----------------------------------------------------------------------------
module arc4_keystream_cipher_test;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET = 950;
   localparam int         QUIET_FROM  = 850;

   class keystream_predictor;
      logic [7:0]                 perm [arc4_pkg::PERM_DEPTH];
      logic [7:0]                 keys [arc4_pkg::KEY_DEPTH];
      logic [7:0]                 idx_i;
      logic [7:0]                 idx_j;
      logic [arc4_pkg::LEN_W-1:0] key_len;
      logic [7:0]                 expected_bytes [$];
      int                         mismatch_count;

      function new();
         for (int k = 0; k < arc4_pkg::PERM_DEPTH; k++) begin
            perm[k] = k[7:0];
            keys[k] = 8'h00;
         end
         idx_i = 8'h00;
         idx_j = 8'h00;
         key_len = arc4_pkg::KEY_LENGTH_RESET;
         mismatch_count = 0;
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      function void swap_entries(logic [7:0] x, logic [7:0] y);
         logic [7:0] t;
         t = perm[x];
         perm[x] = perm[y];
         perm[y] = t;
      endfunction

      function void run_schedule();
         int unsigned len;
         logic [7:0] j;
         len = (key_len == 0) ? 1 : ((key_len > arc4_pkg::KEY_DEPTH) ? arc4_pkg::KEY_DEPTH
                                                                      : key_len);
         for (int k = 0; k < arc4_pkg::PERM_DEPTH; k++) perm[k] = k[7:0];
         j = 8'h00;
         for (int k = 0; k < arc4_pkg::PERM_DEPTH; k++) begin
            j = j + perm[k] + keys[k % len];
            swap_entries(k[7:0], j);
         end
         idx_i = 8'h00;
         idx_j = 8'h00;
      endfunction

      function void set_key_length(logic [arc4_pkg::LEN_W-1:0] v);
         key_len = v;
      endfunction

      function void take_command(logic [1:0] op, logic [7:0] kidx, logic [7:0] val);
         logic [7:0] sum;
         case (op)
            arc4_pkg::OP_KEY_WRITE: begin
               keys[kidx] = val;
            end
            arc4_pkg::OP_SCHEDULE: begin
               run_schedule();
            end
            arc4_pkg::OP_DATA: begin
               idx_i = idx_i + 8'd1;
               idx_j = idx_j + perm[idx_i];
               swap_entries(idx_i, idx_j);
               sum = perm[idx_i] + perm[idx_j];
               expected_bytes.insert(expected_bytes.size(), val ^ perm[sum]);
            end
            default: begin
            end
         endcase
      endfunction

      task check_byte(logic [7:0] got);
         logic [7:0] want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("result word 0x%02h with none expected", got));
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want)
               report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h", got, want));
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_operation = arc4_pkg::OP_KEY_WRITE;
   logic [7:0]                 req_key_index = 8'h00;
   logic [7:0]                 req_value = 8'h00;
   logic                       rsp_strobe;
   logic [7:0]                 rsp_out_byte;
   logic                       csr_write_enable = 1'b0;
   logic [arc4_pkg::LEN_W-1:0] csr_write_data = '0;

   keystream_predictor sb = new();
   bit                 key_loaded [arc4_pkg::KEY_DEPTH];
   int unsigned        cur_len = 16;
   int                 items_sent = 0;
   bit                 gaps_on = 1'b1;

   arc4_keystream_cipher dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key_index    (req_key_index),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_byte     (rsp_out_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_byte(rsp_out_byte);
         if (start && !busy) sb.take_command(req_operation, req_key_index, req_value);
         if (csr_write_enable) sb.set_key_length(csr_write_data);
      end
   end

   task automatic send(logic [1:0] op, logic [7:0] kidx, logic [7:0] val);
      int unsigned gap;
      gap = 0;
      if (gaps_on && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 13);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_key_index <= kidx;
      req_value <= val;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == arc4_pkg::OP_KEY_WRITE) key_loaded[kidx] = 1'b1;
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Stops issuing words until every expected result word is back and the
   // engine has gone idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_key_length(logic [arc4_pkg::LEN_W-1:0] v);
      drain();
      csr_write_data <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_len = (v == 0) ? 1 : ((v > arc4_pkg::KEY_DEPTH) ? arc4_pkg::KEY_DEPTH : v);
   endtask

   // A schedule must never read a key byte that was never written.
   task automatic fill_keys();
      for (int k = 0; k < cur_len; k++)
         if (!key_loaded[k]) send(arc4_pkg::OP_KEY_WRITE, k[7:0], 8'($urandom_range(0, 255)));
   endtask

   task automatic stream_word();
      int unsigned roll;
      roll = $urandom_range(0, 39);
      if (roll == 0) begin
         send(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (roll < 3) begin
         send(arc4_pkg::OP_KEY_WRITE, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
      end else if (roll == 3) begin
         fill_keys();
         send(arc4_pkg::OP_SCHEDULE, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
      end else begin
         send(arc4_pkg::OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_phase(int phase);
      logic [arc4_pkg::LEN_W-1:0] len;
      case (phase)
         0: len = 9'h1FF;
         1: len = arc4_pkg::LEN_W'(arc4_pkg::KEY_DEPTH);
         default: begin
            case ($urandom_range(0, 9))
               0: len = '0;
               1: len = 9'd1;
               2: len = arc4_pkg::LEN_W'(arc4_pkg::KEY_DEPTH);
               3: len = arc4_pkg::LEN_W'($urandom_range(arc4_pkg::KEY_DEPTH + 1, 511));
               default: len = arc4_pkg::LEN_W'($urandom_range(1, 32));
            endcase
         end
      endcase
      write_key_length(len);
      gaps_on = ($urandom_range(0, 2) != 0);
      fill_keys();
      repeat ($urandom_range(1, 3)) begin
         repeat ($urandom_range(0, 4))
            send(arc4_pkg::OP_KEY_WRITE, 8'($urandom_range(0, cur_len - 1)),
                 8'($urandom_range(0, 255)));
         send(arc4_pkg::OP_SCHEDULE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         repeat ($urandom_range(4, 40)) stream_word();
      end
   endtask

   initial begin
      int phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(OP_UNUSED, 8'hFF, 8'hFF);
      send(arc4_pkg::OP_DATA, 8'h00, 8'h00);
      send(arc4_pkg::OP_DATA, 8'hFF, 8'hFF);
      write_key_length(9'd1);
      send(arc4_pkg::OP_KEY_WRITE, 8'h00, 8'hFF);
      send(arc4_pkg::OP_SCHEDULE, 8'h00, 8'h00);
      send(arc4_pkg::OP_DATA, 8'h00, 8'h00);
      send(arc4_pkg::OP_DATA, 8'h00, 8'hFF);
      send(arc4_pkg::OP_DATA, 8'h00, 8'hA5);
      send(arc4_pkg::OP_KEY_WRITE, 8'hFF, 8'h00);
      send(arc4_pkg::OP_KEY_WRITE, 8'h80, 8'h5A);
      send(OP_UNUSED, 8'h00, 8'h00);
      send(arc4_pkg::OP_DATA, 8'h00, 8'h3C);
      write_key_length('0);
      send(arc4_pkg::OP_KEY_WRITE, 8'h00, 8'h00);
      send(arc4_pkg::OP_SCHEDULE, 8'hFF, 8'hFF);
      send(arc4_pkg::OP_DATA, 8'h00, 8'h3C);
      send(arc4_pkg::OP_DATA, 8'h00, 8'hC3);
      write_key_length(9'd2);
      send(arc4_pkg::OP_KEY_WRITE, 8'h01, 8'h80);
      send(arc4_pkg::OP_SCHEDULE, 8'h00, 8'h00);
      send(arc4_pkg::OP_DATA, 8'h00, 8'h01);
      send(arc4_pkg::OP_DATA, 8'h00, 8'hFE);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         random_phase(phase);
         phase++;
      end

      drain();
      repeat (16) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/arc4_pkg.sv
rtl/core/arc4_ram.sv
rtl/core/arc4_keystream_cipher.sv
rtl/core/arc4_checker.sv
tb/sv/arc4_keystream_cipher_test.sv
